// ===== rtl/tftp_pkg.sv =====
// Shared types, codes and constants for the TFTP transfer controller.
package tftp_pkg;

  // Largest packet in bytes, header included.
  localparam int MAX_PACKET_DEF = 516;
  localparam logic [3:0] RETRY_LIMIT_RST = 4'd5;

  // Event types.
  localparam logic [1:0] REQ_PACKET  = 2'd0;
  localparam logic [1:0] REQ_TIMEOUT = 2'd1;
  localparam logic [1:0] REQ_CHUNK   = 2'd2;

  // Packet opcodes.
  localparam logic [15:0] OP_RRQ   = 16'd1;
  localparam logic [15:0] OP_WRQ   = 16'd2;
  localparam logic [15:0] OP_DATA  = 16'd3;
  localparam logic [15:0] OP_ACK   = 16'd4;
  localparam logic [15:0] OP_ERROR = 16'd5;

  // Sent actions.
  localparam logic [1:0] ACT_NONE  = 2'd0;
  localparam logic [1:0] ACT_DATA  = 2'd1;
  localparam logic [1:0] ACT_ACK   = 2'd2;
  localparam logic [1:0] ACT_ERROR = 2'd3;

  // Error codes carried in a sent ERROR packet.
  localparam logic [2:0] ERR_UNDEF      = 3'd0;
  localparam logic [2:0] ERR_ILLEGAL_OP = 3'd4;

  // Session status.
  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_BUSY   = 2'd1;
  localparam logic [1:0] ST_DONE   = 2'd2;
  localparam logic [1:0] ST_FAILED = 2'd3;

  // Failure reasons.
  localparam logic [2:0] WHY_NONE     = 3'd0;
  localparam logic [2:0] WHY_TIMEOUT  = 3'd1;
  localparam logic [2:0] WHY_CLIENT   = 3'd2;
  localparam logic [2:0] WHY_BAD_LEN  = 3'd3;
  localparam logic [2:0] WHY_BAD_OP   = 3'd4;
  localparam logic [2:0] WHY_BAD_BLK  = 3'd5;
  localparam logic [2:0] WHY_FILE     = 3'd6;

  typedef enum logic [3:0] {
    PH_IDLE   = 4'b0001,
    PH_RDWAIT = 4'b0010,
    PH_RDACK  = 4'b0100,
    PH_WRITE  = 4'b1000
  } phase_e;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [15:0] pkt_opcode;
    logic [15:0] pkt_block;
    logic [9:0]  pkt_len;
    logic        file_ok;
    logic [9:0]  chunk_len;
  } item_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [15:0] block_num;
    logic [9:0]  data_len;
    logic        store_payload;
    logic [2:0]  err_code;
    logic        want_chunk;
    logic [1:0]  status;
    logic [2:0]  fail_reason;
  } result_t;

  typedef struct packed {
    phase_e      phase;
    logic [15:0] cur_block;
    logic [3:0]  timeouts_seen;
    logic        last_block_flag;
    logic [9:0]  held_chunk_len;
  } state_t;

endpackage

// ===== rtl/tftp_step.sv =====
// Next-state and result logic for one event of the TFTP session.
module tftp_step #(
  parameter int MaxPacket = tftp_pkg::MAX_PACKET_DEF
) (
  input  tftp_pkg::item_t   item_i,
  input  tftp_pkg::state_t  st_i,
  input  logic [3:0]        retry_limit_i,
  output tftp_pkg::state_t  st_o,
  output logic              res_valid_o,
  output tftp_pkg::result_t res_o
);

  localparam logic [16:0] MaxPkt   = 17'(MaxPacket);
  localparam logic [16:0] ChunkCap = 17'(MaxPacket - 4);

  logic [16:0] plen_ext;
  logic [16:0] clen_ext;
  logic [16:0] n_len;
  logic [16:0] c_len;
  logic [15:0] next_blk;
  logic [4:0]  tmo_cnt;

  assign plen_ext = {7'd0, item_i.pkt_len};
  assign clen_ext = {7'd0, item_i.chunk_len};
  assign n_len    = (plen_ext > MaxPkt) ? MaxPkt : plen_ext;
  assign c_len    = (clen_ext > ChunkCap) ? ChunkCap : clen_ext;
  assign next_blk = st_i.cur_block + 16'd1;
  assign tmo_cnt  = {1'b0, st_i.timeouts_seen} + 5'd1;

  always_comb begin
    st_o        = st_i;
    res_valid_o = 1'b0;
    res_o       = '0;
    unique case (item_i.req_type)
      tftp_pkg::REQ_PACKET: begin
        priority if (st_i.phase == tftp_pkg::PH_RDWAIT) begin
          // drop packets while the next chunk is pending
        end else if (n_len < 17'd4) begin
          st_o.phase        = tftp_pkg::PH_IDLE;
          res_valid_o       = 1'b1;
          res_o.action      = tftp_pkg::ACT_ERROR;
          res_o.err_code    = tftp_pkg::ERR_ILLEGAL_OP;
          res_o.status      = tftp_pkg::ST_FAILED;
          res_o.fail_reason = tftp_pkg::WHY_BAD_LEN;
        end else if (st_i.phase == tftp_pkg::PH_IDLE) begin
          priority if (item_i.pkt_opcode == tftp_pkg::OP_RRQ) begin
            res_valid_o = 1'b1;
            if (!item_i.file_ok) begin
              res_o.action      = tftp_pkg::ACT_ERROR;
              res_o.err_code    = tftp_pkg::ERR_UNDEF;
              res_o.status      = tftp_pkg::ST_FAILED;
              res_o.fail_reason = tftp_pkg::WHY_FILE;
            end else begin
              st_o.phase           = tftp_pkg::PH_RDWAIT;
              st_o.cur_block       = 16'd1;
              st_o.timeouts_seen   = 4'd0;
              st_o.last_block_flag = 1'b0;
              res_o.want_chunk     = 1'b1;
              res_o.status         = tftp_pkg::ST_BUSY;
            end
          end else if (item_i.pkt_opcode == tftp_pkg::OP_WRQ) begin
            res_valid_o = 1'b1;
            if (!item_i.file_ok) begin
              res_o.action      = tftp_pkg::ACT_ERROR;
              res_o.err_code    = tftp_pkg::ERR_ILLEGAL_OP;
              res_o.status      = tftp_pkg::ST_FAILED;
              res_o.fail_reason = tftp_pkg::WHY_FILE;
            end else begin
              st_o.phase           = tftp_pkg::PH_WRITE;
              st_o.cur_block       = 16'd0;
              st_o.timeouts_seen   = 4'd0;
              st_o.last_block_flag = 1'b0;
              res_o.action         = tftp_pkg::ACT_ACK;
              res_o.status         = tftp_pkg::ST_BUSY;
            end
          end else begin
            // ignore other opcodes while idle
          end
        end else if (item_i.pkt_opcode == tftp_pkg::OP_ERROR) begin
          st_o.phase        = tftp_pkg::PH_IDLE;
          res_valid_o       = 1'b1;
          res_o.status      = tftp_pkg::ST_FAILED;
          res_o.fail_reason = tftp_pkg::WHY_CLIENT;
        end else if (st_i.phase == tftp_pkg::PH_RDACK) begin
          res_valid_o = 1'b1;
          priority if (item_i.pkt_opcode != tftp_pkg::OP_ACK) begin
            st_o.phase        = tftp_pkg::PH_IDLE;
            res_o.action      = tftp_pkg::ACT_ERROR;
            res_o.err_code    = tftp_pkg::ERR_ILLEGAL_OP;
            res_o.status      = tftp_pkg::ST_FAILED;
            res_o.fail_reason = tftp_pkg::WHY_BAD_OP;
          end else if (item_i.pkt_block != st_i.cur_block) begin
            st_o.phase        = tftp_pkg::PH_IDLE;
            res_o.action      = tftp_pkg::ACT_ERROR;
            res_o.err_code    = tftp_pkg::ERR_UNDEF;
            res_o.status      = tftp_pkg::ST_FAILED;
            res_o.fail_reason = tftp_pkg::WHY_BAD_BLK;
          end else if (st_i.last_block_flag) begin
            st_o.phase   = tftp_pkg::PH_IDLE;
            res_o.status = tftp_pkg::ST_DONE;
          end else begin
            st_o.phase         = tftp_pkg::PH_RDWAIT;
            st_o.cur_block     = next_blk;
            st_o.timeouts_seen = 4'd0;
            res_o.want_chunk   = 1'b1;
            res_o.status       = tftp_pkg::ST_BUSY;
          end
        end else begin
          // write phase
          res_valid_o = 1'b1;
          priority if (item_i.pkt_opcode != tftp_pkg::OP_DATA) begin
            st_o.phase        = tftp_pkg::PH_IDLE;
            res_o.action      = tftp_pkg::ACT_ERROR;
            res_o.err_code    = tftp_pkg::ERR_ILLEGAL_OP;
            res_o.status      = tftp_pkg::ST_FAILED;
            res_o.fail_reason = tftp_pkg::WHY_BAD_OP;
          end else if (item_i.pkt_block != next_blk) begin
            st_o.phase        = tftp_pkg::PH_IDLE;
            res_o.action      = tftp_pkg::ACT_ERROR;
            res_o.err_code    = tftp_pkg::ERR_UNDEF;
            res_o.status      = tftp_pkg::ST_FAILED;
            res_o.fail_reason = tftp_pkg::WHY_BAD_BLK;
          end else begin
            st_o.cur_block       = next_blk;
            st_o.timeouts_seen   = 4'd0;
            st_o.last_block_flag = (n_len < MaxPkt);
            if (n_len < MaxPkt) begin
              st_o.phase = tftp_pkg::PH_IDLE;
            end
            res_o.action        = tftp_pkg::ACT_ACK;
            res_o.block_num     = next_blk;
            res_o.data_len      = 10'(n_len - 17'd4);
            res_o.store_payload = 1'b1;
            res_o.status        = (n_len < MaxPkt) ? tftp_pkg::ST_DONE : tftp_pkg::ST_BUSY;
          end
        end
      end
      tftp_pkg::REQ_TIMEOUT: begin
        if (st_i.phase == tftp_pkg::PH_RDACK || st_i.phase == tftp_pkg::PH_WRITE) begin
          res_valid_o = 1'b1;
          if (tmo_cnt >= {1'b0, retry_limit_i}) begin
            st_o.phase        = tftp_pkg::PH_IDLE;
            res_o.status      = tftp_pkg::ST_FAILED;
            res_o.fail_reason = tftp_pkg::WHY_TIMEOUT;
          end else begin
            st_o.timeouts_seen = tmo_cnt[3:0];
            res_o.status       = tftp_pkg::ST_BUSY;
            if (st_i.phase == tftp_pkg::PH_RDACK) begin
              res_o.action    = tftp_pkg::ACT_DATA;
              res_o.block_num = st_i.cur_block;
              res_o.data_len  = st_i.held_chunk_len;
            end
          end
        end
      end
      tftp_pkg::REQ_CHUNK: begin
        if (st_i.phase == tftp_pkg::PH_RDWAIT) begin
          st_o.held_chunk_len  = c_len[9:0];
          st_o.last_block_flag = (c_len < ChunkCap);
          st_o.phase           = tftp_pkg::PH_RDACK;
          st_o.timeouts_seen   = 4'd0;
          res_valid_o          = 1'b1;
          res_o.action         = tftp_pkg::ACT_DATA;
          res_o.block_num      = st_i.cur_block;
          res_o.data_len       = c_len[9:0];
          res_o.status         = tftp_pkg::ST_BUSY;
        end
      end
      default: begin
        // unused event type: no result
      end
    endcase
  end

endmodule

// ===== rtl/tftp_transfer_controller.sv =====
// Top level of the TFTP server transfer controller: event register, session state, result register.
//
// One TFTP server session (RFC 1350 transfer engine). Each accepted input
// transfer is one event: a received packet, a receive timeout or a ready file
// chunk. An event lands in the input register, is evaluated against the
// session state in one pass of combinational logic, and its result (if it
// has one) is loaded into the output register when the event moves on, which
// waits while a stalled result still fills the output register. The block
// takes one event per cycle; the only thing that holds the input side back
// is the output register being full while the consumer stalls it. Events
// that cause no result still pass through the event register.
// retry_limit is written through its own write enable and takes effect from
// the next event; write it only while idle.
module tftp_transfer_controller #(
  parameter int MaxPacket = tftp_pkg::MAX_PACKET_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        retry_limit_we_i,
  input  logic [3:0]  retry_limit_i,
  // event channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  req_type_i,
  input  logic [15:0] pkt_opcode_i,
  input  logic [15:0] pkt_block_i,
  input  logic [9:0]  pkt_len_i,
  input  logic        file_ok_i,
  input  logic [9:0]  chunk_len_i,
  // result channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  action_o,
  output logic [15:0] block_num_o,
  output logic [9:0]  data_len_o,
  output logic        store_payload_o,
  output logic [2:0]  err_code_o,
  output logic        want_chunk_o,
  output logic [1:0]  status_o,
  output logic [2:0]  fail_reason_o
);

  logic [3:0]        retry_limit_q;
  tftp_pkg::item_t   item_q;
  logic              item_valid_q;
  logic              item_valid_d;
  tftp_pkg::state_t  state_q;
  tftp_pkg::state_t  state_d;
  tftp_pkg::result_t res_q;
  tftp_pkg::result_t step_res;
  logic              step_res_valid;
  logic              out_valid_q;
  logic              out_valid_d;
  logic              advance;
  logic              in_take;

  // Advance the event register whenever the result register is free or drains now.
  assign advance    = item_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = item_valid_q && !advance;
  assign in_take    = in_valid_i && !in_stall_o;

  assign item_valid_d = in_take || (item_valid_q && !advance);
  assign out_valid_d  = (advance && step_res_valid) || (out_valid_q && out_stall_i);

  tftp_step #(
    .MaxPacket(MaxPacket)
  ) u_step (
    .item_i       (item_q),
    .st_i         (state_q),
    .retry_limit_i(retry_limit_q),
    .st_o         (state_d),
    .res_valid_o  (step_res_valid),
    .res_o        (step_res)
  );

  // Control state: configuration, session state, valid flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      retry_limit_q         <= tftp_pkg::RETRY_LIMIT_RST;
      item_valid_q          <= 1'b0;
      out_valid_q           <= 1'b0;
      state_q.phase         <= tftp_pkg::PH_IDLE;
      state_q.cur_block     <= '0;
      state_q.timeouts_seen <= '0;
      state_q.last_block_flag <= 1'b0;
      state_q.held_chunk_len  <= '0;
    end else begin
      if (retry_limit_we_i) begin
        retry_limit_q <= retry_limit_i;
      end
      item_valid_q <= item_valid_d;
      out_valid_q  <= out_valid_d;
      // commit the session update only when the event moves on
      if (advance) begin
        state_q <= state_d;
      end
    end
  end

  // Payload registers: capture on transfer, hold otherwise.
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      item_q.req_type   <= req_type_i;
      item_q.pkt_opcode <= pkt_opcode_i;
      item_q.pkt_block  <= pkt_block_i;
      item_q.pkt_len    <= pkt_len_i;
      item_q.file_ok    <= file_ok_i;
      item_q.chunk_len  <= chunk_len_i;
    end
    if (advance && step_res_valid) begin
      res_q <= step_res;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign action_o        = res_q.action;
  assign block_num_o     = res_q.block_num;
  assign data_len_o      = res_q.data_len;
  assign store_payload_o = res_q.store_payload;
  assign err_code_o      = res_q.err_code;
  assign want_chunk_o    = res_q.want_chunk;
  assign status_o        = res_q.status;
  assign fail_reason_o   = res_q.fail_reason;

endmodule

// ===== rtl/tftp_checker.sv =====
// Port-level assertions for the TFTP transfer controller and their bind.
module tftp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [1:0]  action_o,
  input logic [15:0] block_num_o,
  input logic [9:0]  data_len_o,
  input logic        store_payload_o,
  input logic        want_chunk_o,
  input logic [1:0]  status_o
);

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(action_o)
      && $stable(block_num_o) && $stable(data_len_o) && $stable(status_o))
    else $error("stalled result changed");

  // Input side only stalls behind a full result register.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled with empty output");

  // Every sent ERROR ends the session as failed.
  a_err_fails: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && action_o == tftp_pkg::ACT_ERROR |-> status_o == tftp_pkg::ST_FAILED)
    else $error("ERROR sent without failure status");

  // Stored payload always comes with its ACK.
  a_store_ack: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && store_payload_o |-> action_o == tftp_pkg::ACT_ACK)
    else $error("payload stored without ACK");

  // A chunk request sends nothing and keeps the session running.
  a_want_chunk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && want_chunk_o |->
      action_o == tftp_pkg::ACT_NONE && status_o == tftp_pkg::ST_BUSY)
    else $error("chunk request with action or wrong status");

endmodule

bind tftp_transfer_controller tftp_checker u_tftp_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_stall_o     (in_stall_o),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .action_o       (action_o),
  .block_num_o    (block_num_o),
  .data_len_o     (data_len_o),
  .store_payload_o(store_payload_o),
  .want_chunk_o   (want_chunk_o),
  .status_o       (status_o)
);

// ===== tb/tb.sv =====
// Self-checking testbench for the TFTP server transfer controller.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tftp_pkg::*;

  localparam int CLK_PERIOD     = 10;
  localparam int RESET_CYCLES   = 4;
  // Slack after the last expected result, for the pipe to settle.
  localparam int SETTLE_CYCLES  = 4;
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PHASE_REPLIES  = 200;
  localparam int MAX_PRINTED    = 40;

  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam logic [9:0] PKT_MAX    = 10'(MAX_PACKET_DEF);
  localparam logic [9:0] CHUNK_MAX  = 10'(MAX_PACKET_DEF - 4);

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        retry_limit_we_i = 1'b0;
  logic [3:0]  retry_limit_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [1:0]  req_type_i = '0;
  logic [15:0] pkt_opcode_i = '0;
  logic [15:0] pkt_block_i = '0;
  logic [9:0]  pkt_len_i = '0;
  logic        file_ok_i = 1'b0;
  logic [9:0]  chunk_len_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [1:0]  action_o;
  logic [15:0] block_num_o;
  logic [9:0]  data_len_o;
  logic        store_payload_o;
  logic [2:0]  err_code_o;
  logic        want_chunk_o;
  logic [1:0]  status_o;
  logic [2:0]  fail_reason_o;

  tftp_transfer_controller DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .retry_limit_we_i(retry_limit_we_i),
    .retry_limit_i   (retry_limit_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .req_type_i      (req_type_i),
    .pkt_opcode_i    (pkt_opcode_i),
    .pkt_block_i     (pkt_block_i),
    .pkt_len_i       (pkt_len_i),
    .file_ok_i       (file_ok_i),
    .chunk_len_i     (chunk_len_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .action_o        (action_o),
    .block_num_o     (block_num_o),
    .data_len_o      (data_len_o),
    .store_payload_o (store_payload_o),
    .err_code_o      (err_code_o),
    .want_chunk_o    (want_chunk_o),
    .status_o        (status_o),
    .fail_reason_o   (fail_reason_o)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Session predictor: our own copy of the server session and its retry limit.
  // ---------------------------------------------------------------------------
  phase_e      sess_phase;
  logic [15:0] sess_block;
  logic [3:0]  sess_timeouts;
  logic        sess_last;
  logic [9:0]  sess_chunk;
  logic [3:0]  retry_cfg;

  result_t     expected_replies[$];
  int          replies_due;
  int          error_count;

  // Idle knobs, set per test phase.
  int          sender_idle_pct;
  int          recv_stall_pct;
  int          holds_asked;

  function automatic result_t reply(logic [1:0] act, logic [15:0] blk, logic [9:0] len,
                                    logic store, logic [2:0] err, logic want,
                                    logic [1:0] st, logic [2:0] why);
    result_t r;
    r = '{action: act, block_num: blk, data_len: len, store_payload: store,
          err_code: err, want_chunk: want, status: st, fail_reason: why};
    return r;
  endfunction

  // Drop the session back to idle and report the failure.
  function automatic result_t abort_session(logic [1:0] act, logic [2:0] err, logic [2:0] why);
    sess_phase = PH_IDLE;
    return reply(act, '0, '0, 1'b0, err, 1'b0, ST_FAILED, why);
  endfunction

  // Advance the session by one event; return 1 when the event yields a result.
  function automatic bit session_step(input item_t ev, output result_t r);
    logic [9:0]  plen;
    logic [9:0]  clen;
    logic [15:0] nxt;
    logic [4:0]  tries;
    logic        fin;
    r = '0;
    // Oversized packets and chunks are truncated to the largest legal size.
    plen = (ev.pkt_len > PKT_MAX) ? PKT_MAX : ev.pkt_len;
    clen = (ev.chunk_len > CHUNK_MAX) ? CHUNK_MAX : ev.chunk_len;
    case (ev.req_type)
      REQ_PACKET: begin
        // Packets are not looked at while a file chunk is pending.
        if (sess_phase == PH_RDWAIT) return 1'b0;
        if (plen < 10'd4) begin
          r = abort_session(ACT_ERROR, ERR_ILLEGAL_OP, WHY_BAD_LEN);
          return 1'b1;
        end
        if (sess_phase == PH_IDLE) begin
          if (ev.pkt_opcode == OP_RRQ) begin
            if (!ev.file_ok) begin
              r = abort_session(ACT_ERROR, ERR_UNDEF, WHY_FILE);
              return 1'b1;
            end
            sess_phase    = PH_RDWAIT;
            sess_block    = 16'd1;
            sess_timeouts = '0;
            sess_last     = 1'b0;
            r = reply(ACT_NONE, '0, '0, 1'b0, ERR_UNDEF, 1'b1, ST_BUSY, WHY_NONE);
            return 1'b1;
          end
          if (ev.pkt_opcode == OP_WRQ) begin
            if (!ev.file_ok) begin
              r = abort_session(ACT_ERROR, ERR_ILLEGAL_OP, WHY_FILE);
              return 1'b1;
            end
            sess_phase    = PH_WRITE;
            sess_block    = '0;
            sess_timeouts = '0;
            sess_last     = 1'b0;
            r = reply(ACT_ACK, '0, '0, 1'b0, ERR_UNDEF, 1'b0, ST_BUSY, WHY_NONE);
            return 1'b1;
          end
          return 1'b0;
        end
        if (ev.pkt_opcode == OP_ERROR) begin
          r = abort_session(ACT_NONE, ERR_UNDEF, WHY_CLIENT);
          return 1'b1;
        end
        if (sess_phase == PH_RDACK) begin
          if (ev.pkt_opcode != OP_ACK) begin
            r = abort_session(ACT_ERROR, ERR_ILLEGAL_OP, WHY_BAD_OP);
            return 1'b1;
          end
          if (ev.pkt_block != sess_block) begin
            r = abort_session(ACT_ERROR, ERR_UNDEF, WHY_BAD_BLK);
            return 1'b1;
          end
          if (sess_last) begin
            sess_phase = PH_IDLE;
            r = reply(ACT_NONE, '0, '0, 1'b0, ERR_UNDEF, 1'b0, ST_DONE, WHY_NONE);
            return 1'b1;
          end
          sess_block    = sess_block + 16'd1;
          sess_phase    = PH_RDWAIT;
          sess_timeouts = '0;
          r = reply(ACT_NONE, '0, '0, 1'b0, ERR_UNDEF, 1'b1, ST_BUSY, WHY_NONE);
          return 1'b1;
        end
        // Write session: expect the next DATA block in order.
        nxt = sess_block + 16'd1;
        if (ev.pkt_opcode != OP_DATA) begin
          r = abort_session(ACT_ERROR, ERR_ILLEGAL_OP, WHY_BAD_OP);
          return 1'b1;
        end
        if (ev.pkt_block != nxt) begin
          r = abort_session(ACT_ERROR, ERR_UNDEF, WHY_BAD_BLK);
          return 1'b1;
        end
        sess_block    = nxt;
        sess_timeouts = '0;
        fin           = (plen < PKT_MAX);
        sess_last     = fin;
        if (fin) sess_phase = PH_IDLE;
        r = reply(ACT_ACK, nxt, plen - 10'd4, 1'b1, ERR_UNDEF, 1'b0,
                  fin ? ST_DONE : ST_BUSY, WHY_NONE);
        return 1'b1;
      end
      REQ_TIMEOUT: begin
        if (sess_phase != PH_RDACK && sess_phase != PH_WRITE) return 1'b0;
        tries = {1'b0, sess_timeouts} + 5'd1;
        if (tries >= {1'b0, retry_cfg}) begin
          r = abort_session(ACT_NONE, ERR_UNDEF, WHY_TIMEOUT);
          return 1'b1;
        end
        sess_timeouts = tries[3:0];
        // A read resends the held block; a write only counts.
        if (sess_phase == PH_RDACK)
          r = reply(ACT_DATA, sess_block, sess_chunk, 1'b0, ERR_UNDEF, 1'b0, ST_BUSY, WHY_NONE);
        else
          r = reply(ACT_NONE, '0, '0, 1'b0, ERR_UNDEF, 1'b0, ST_BUSY, WHY_NONE);
        return 1'b1;
      end
      REQ_CHUNK: begin
        if (sess_phase != PH_RDWAIT) return 1'b0;
        sess_chunk    = clen;
        sess_last     = (clen < CHUNK_MAX);
        sess_phase    = PH_RDACK;
        sess_timeouts = '0;
        r = reply(ACT_DATA, sess_block, clen, 1'b0, ERR_UNDEF, 1'b0, ST_BUSY, WHY_NONE);
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Event builders.
  // ---------------------------------------------------------------------------
  function automatic item_t noise_event();
    item_t ev;
    ev.req_type   = 2'($urandom_range(0, 3));
    ev.pkt_opcode = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(0, 7)) : 16'($urandom);
    ev.pkt_block  = 16'($urandom);
    ev.pkt_len    = 10'($urandom);
    ev.file_ok    = 1'($urandom);
    ev.chunk_len  = 10'($urandom);
    return ev;
  endfunction

  function automatic item_t pkt_event(logic [15:0] op, logic [15:0] blk, logic [9:0] len,
                                      logic ok);
    item_t ev;
    ev            = noise_event();
    ev.req_type   = REQ_PACKET;
    ev.pkt_opcode = op;
    ev.pkt_block  = blk;
    ev.pkt_len    = len;
    ev.file_ok    = ok;
    return ev;
  endfunction

  function automatic item_t tick_event(logic [1:0] req, logic [9:0] clen);
    item_t ev;
    ev           = noise_event();
    ev.req_type  = req;
    ev.chunk_len = clen;
    return ev;
  endfunction

  // Pick the event a well-behaved client and host would produce next.
  function automatic item_t plausible_event();
    item_t ev;
    int    pick;
    int    roll;
    pick = $urandom_range(0, 99);
    roll = $urandom_range(0, 99);
    case (sess_phase)
      PH_IDLE:
        ev = pkt_event((pick < 50) ? OP_RRQ : OP_WRQ, 16'($urandom), 10'($urandom_range(4, 80)),
                       roll < 92);
      PH_RDWAIT: begin
        if (pick < 70)      ev = tick_event(REQ_CHUNK, CHUNK_MAX);
        else if (pick < 92) ev = tick_event(REQ_CHUNK, 10'($urandom_range(0, 511)));
        else                ev = tick_event(REQ_CHUNK, 10'($urandom_range(513, 1023)));
      end
      PH_RDACK: begin
        if (pick < 12) ev = tick_event(REQ_TIMEOUT, 10'($urandom));
        else           ev = pkt_event(OP_ACK, sess_block, 10'($urandom_range(4, 40)), 1'($urandom));
      end
      default: begin
        if (pick < 12) ev = tick_event(REQ_TIMEOUT, 10'($urandom));
        else if (roll < 70)
          ev = pkt_event(OP_DATA, sess_block + 16'd1, PKT_MAX, 1'($urandom));
        else if (roll < 93)
          ev = pkt_event(OP_DATA, sess_block + 16'd1, 10'($urandom_range(4, 515)), 1'($urandom));
        else
          ev = pkt_event(OP_DATA, sess_block + 16'd1, 10'($urandom_range(517, 1023)),
                         1'($urandom));
      end
    endcase
    return ev;
  endfunction

  // Take a plausible event and spoil one thing about it.
  function automatic item_t broken_event();
    item_t ev;
    ev = plausible_event();
    case ($urandom_range(0, 3))
      0: ev.pkt_len = 10'($urandom_range(0, 3));
      1: ev.pkt_block = ev.pkt_block + (($urandom_range(0, 1) == 0) ? 16'd1 : 16'hFFFF);
      2: ev.pkt_opcode = OP_ERROR;
      default: ev.req_type = REQ_PACKET;
    endcase
    return ev;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver, configuration and housekeeping tasks.
  // ---------------------------------------------------------------------------
  task automatic report_error(input string msg);
    error_count++;
    if (error_count <= MAX_PRINTED) $display("tb: %0t: %s", $realtime, msg);
  endtask

  // Offer one event, hold it until the block takes it, then predict its result.
  task automatic send_event(input item_t ev);
    result_t want;
    if (sender_idle_pct > 0 && $urandom_range(0, 99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < sender_idle_pct);
    end
    in_valid_i   <= 1'b1;
    req_type_i   <= ev.req_type;
    pkt_opcode_i <= ev.pkt_opcode;
    pkt_block_i  <= ev.pkt_block;
    pkt_len_i    <= ev.pkt_len;
    file_ok_i    <= ev.file_ok;
    chunk_len_i  <= ev.chunk_len;
    do @(posedge clk_i); while (in_stall_o);
    if (session_step(ev, want)) begin
      expected_replies.push_back(want);
      replies_due++;
    end
  endtask

  // Drop valid, let every expected result drain, then let the pipe settle.
  task automatic wait_quiet();
    in_valid_i <= 1'b0;
    while (expected_replies.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Bring the session back to idle so the retry limit may be rewritten.
  task automatic close_session();
    while (sess_phase != PH_IDLE) begin
      if (sess_phase == PH_RDWAIT) send_event(tick_event(REQ_CHUNK, CHUNK_MAX));
      else send_event(pkt_event(OP_ERROR, '0, 10'd4, 1'b0));
    end
    wait_quiet();
  endtask

  task automatic set_retry_limit(input logic [3:0] limit);
    retry_limit_we_i <= 1'b1;
    retry_limit_i    <= limit;
    @(posedge clk_i);
    retry_limit_we_i <= 1'b0;
    retry_cfg = limit;
  endtask

  task automatic set_idling(input int send_pct, input int stall_pct);
    sender_idle_pct = send_pct;
    recv_stall_pct  = stall_pct;
  endtask

  // ---------------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------------

  // Walk each rule of the session once, at the reset retry limit.
  task automatic test_directed_cases();
    set_idling(0, 0);
    send_event(pkt_event(OP_ACK, '0, 10'd3, 1'b1));          // runt packet while idle
    send_event(pkt_event(OP_ACK, '0, 10'd4, 1'b1));          // stray opcode while idle
    send_event(tick_event(REQ_UNUSED, '0));                   // unused event type
    send_event(tick_event(REQ_TIMEOUT, '0));                  // timeout while idle
    send_event(tick_event(REQ_CHUNK, CHUNK_MAX));             // chunk while idle
    send_event(pkt_event(OP_RRQ, '0, 10'd20, 1'b0));          // read refused
    send_event(pkt_event(OP_WRQ, '0, 10'd20, 1'b0));          // write refused
    // Read session: oversized request, ignored traffic while the chunk is pending.
    send_event(pkt_event(OP_RRQ, 16'hFFFF, 10'h3FF, 1'b1));
    send_event(pkt_event(OP_ACK, 16'd1, 10'd4, 1'b1));
    send_event(tick_event(REQ_TIMEOUT, '0));
    send_event(tick_event(REQ_CHUNK, 10'h3FF));               // oversized chunk
    send_event(tick_event(REQ_TIMEOUT, '0));                  // resend block 1
    send_event(pkt_event(OP_ACK, 16'd1, 10'd4, 1'b0));
    send_event(tick_event(REQ_CHUNK, '0));                    // empty last chunk
    send_event(pkt_event(OP_ACK, 16'd7, 10'd4, 1'b0));        // wrong block
    // Write session with a counted timeout and an oversized DATA.
    send_event(pkt_event(OP_WRQ, '0, 10'd30, 1'b1));
    send_event(pkt_event(OP_DATA, 16'd1, PKT_MAX, 1'b0));
    send_event(tick_event(REQ_TIMEOUT, '0));
    send_event(pkt_event(OP_DATA, 16'd2, 10'h3FF, 1'b0));
    send_event(pkt_event(OP_DATA, 16'd3, 10'd4, 1'b0));       // empty last block
    send_event(pkt_event(OP_WRQ, '0, 10'd30, 1'b1));
    send_event(pkt_event(OP_ACK, 16'd1, 10'd4, 1'b0));        // wrong opcode in write
    send_event(pkt_event(OP_RRQ, '0, 10'd30, 1'b1));
    send_event(tick_event(REQ_CHUNK, 10'd100));
    send_event(pkt_event(OP_ACK, 16'd1, '0, 1'b0));           // runt packet mid-read
    send_event(pkt_event(OP_WRQ, '0, 10'd30, 1'b1));
    send_event(pkt_event(OP_ERROR, '0, 10'd9, 1'b0));         // client abort
    send_event(pkt_event(OP_WRQ, '0, 10'd30, 1'b1));
    send_event(pkt_event(OP_DATA, 16'd5, PKT_MAX, 1'b0));     // out-of-order block
    close_session();
  endtask

  // Run both session kinds into the retry limit at its extremes.
  task automatic test_retry_exhaustion();
    logic [3:0] limits[2];
    limits = '{4'd1, 4'd15};
    set_idling(19, 19);
    foreach (limits[i]) begin
      close_session();
      set_retry_limit(limits[i]);
      send_event(pkt_event(OP_RRQ, '0, 10'd12, 1'b1));
      send_event(tick_event(REQ_CHUNK, 10'd200));
      while (sess_phase != PH_IDLE) send_event(tick_event(REQ_TIMEOUT, '0));
      send_event(pkt_event(OP_WRQ, '0, 10'd12, 1'b1));
      while (sess_phase != PH_IDLE) send_event(tick_event(REQ_TIMEOUT, '0));
    end
    close_session();
  endtask

  // Stall the result side for a long stretch while events keep coming.
  task automatic test_output_backpressure();
    set_idling(0, 0);
    close_session();
    set_retry_limit(4'd15);
    holds_asked++;
    send_event(pkt_event(OP_WRQ, '0, 10'd16, 1'b1));
    repeat (40) send_event(plausible_event());
    close_session();
  endtask

  // Mostly well-formed sessions with random content, some spoiled, some noise.
  task automatic test_random_sessions();
    int         send_pct[4];
    int         stall_pct[4];
    logic [3:0] limits[4];
    int         start;
    int         pick;
    send_pct  = '{0, 47, 0, 19};
    stall_pct = '{0, 0, 47, 19};
    limits    = '{4'd15, 4'd1, 4'd3, 4'($urandom_range(1, 15))};
    foreach (limits[p]) begin
      close_session();
      set_retry_limit(limits[p]);
      set_idling(send_pct[p], stall_pct[p]);
      start = replies_due;
      while (replies_due - start < PHASE_REPLIES) begin
        pick = $urandom_range(0, 99);
        if (pick < 80)      send_event(plausible_event());
        else if (pick < 88) send_event(broken_event());
        else                send_event(noise_event());
      end
    end
    close_session();
  endtask

  // ---------------------------------------------------------------------------
  // Result side: stall generator with a long hold-off on request.
  // ---------------------------------------------------------------------------
  int holds_taken = 0;
  int hold_left = 0;

  always @(posedge clk_i) begin
    if (holds_taken != holds_asked) begin
      holds_taken  = holds_asked;
      hold_left    = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= (recv_stall_pct > 0) && ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  // Compare each accepted result with the oldest expectation, field by field.
  always @(posedge clk_i) begin : check_replies
    result_t got;
    result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = {action_o, block_num_o, data_len_o, store_payload_o, err_code_o, want_chunk_o,
             status_o, fail_reason_o};
      if (expected_replies.size() == 0) begin
        report_error($sformatf("result with none expected: %p", got));
      end else begin
        want = expected_replies.pop_front();
        if (got.action !== want.action)
          report_error($sformatf("action %0d, expected %0d", got.action, want.action));
        if (got.block_num !== want.block_num)
          report_error($sformatf("block_num %0d, expected %0d", got.block_num, want.block_num));
        if (got.data_len !== want.data_len)
          report_error($sformatf("data_len %0d, expected %0d", got.data_len, want.data_len));
        if (got.store_payload !== want.store_payload)
          report_error($sformatf("store_payload %0d, expected %0d",
                                 got.store_payload, want.store_payload));
        if (got.err_code !== want.err_code)
          report_error($sformatf("err_code %0d, expected %0d",
                                 got.err_code, want.err_code));
        if (got.want_chunk !== want.want_chunk)
          report_error($sformatf("want_chunk %0d, expected %0d",
                                 got.want_chunk, want.want_chunk));
        if (got.status !== want.status)
          report_error($sformatf("status %0d, expected %0d", got.status, want.status));
        if (got.fail_reason !== want.fail_reason)
          report_error($sformatf("fail_reason %0d, expected %0d",
                                 got.fail_reason, want.fail_reason));
      end
    end
  end

  // Watchdog: end the run if nothing moves on either channel for too long.
  int quiet_cycles = 0;

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: watchdog expired, %0d results outstanding", expected_replies.size());
      $display("tb: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence: reset once, run the tests in turn, drain, report.
  // ---------------------------------------------------------------------------
  initial begin
    sess_phase      = PH_IDLE;
    sess_block      = '0;
    sess_timeouts   = '0;
    sess_last       = 1'b0;
    sess_chunk      = '0;
    retry_cfg       = RETRY_LIMIT_RST;
    replies_due     = 0;
    error_count     = 0;
    sender_idle_pct = 0;
    recv_stall_pct  = 0;
    holds_asked     = 0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_cases();
    test_retry_exhaustion();
    test_output_backpressure();
    test_random_sessions();

    wait_quiet();
    if (error_count == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule

// ===== tftp_transfer_controller.f =====
rtl/tftp_pkg.sv
rtl/tftp_step.sv
rtl/tftp_transfer_controller.sv
rtl/tftp_checker.sv
tb/tb.sv
